>>> rtl/core/kabf_pkg.sv
// Shared types, constants and helpers for the angle/bias Kalman filter.
// No dependencies; used by kalman_angle_bias_filter_unit.
package kabf_pkg;

  // Reset values of the noise registers, Q8.24
  localparam logic [30:0] RST_ANGLE_NOISE   = 31'd16777;
  localparam logic [30:0] RST_BIAS_NOISE    = 31'd50332;
  localparam logic [30:0] RST_MEASURE_NOISE = 31'd503316;

  localparam int unsigned MUL_A_W = 36;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_FORCE  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } kabf_op_e;

  typedef enum logic [1:0] {
    REG_ANGLE_NOISE   = 2'd0,
    REG_BIAS_NOISE    = 2'd1,
    REG_MEASURE_NOISE = 2'd2
  } kabf_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_M0,    // (rate - bias) * dt
    ST_M1,    // angle predict, p11 * dt
    ST_M2,    // t, bias_noise * dt
    ST_M3,    // p11/p01/p10 predict, x * dt
    ST_M4,    // p00 predict
    ST_SUM,   // innovation variance
    ST_DSET,  // divider setup
    ST_DRUN,  // one quotient bit a cycle
    ST_DEND,  // sign and saturate gain
    ST_C0,
    ST_C1,
    ST_C2,
    ST_C3,
    ST_C4,
    ST_C5,
    ST_C6,
    ST_OUT
  } kabf_state_e;

  // Saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/kalman_angle_bias_filter_unit.sv
// Two-state (angle, gyro bias) Kalman filter, fixed point, one shared multiplier.
// Depends on kabf_pkg.
//
// Force, clear and unused opcodes present their result the cycle after accept.
// An update result is valid after 5 prediction steps (4 products), the sum, two gains
// from a restoring divider at one quotient bit a cycle (32-bit quotients, plus setup and
// sign fix) and 7 correction steps (6 products). With zero innovation variance the
// divider is skipped.
// One item at a time; ready again the cycle after the result is taken.
// Reset: angle, bias and covariance clear to zero, noise registers take their defaults.
module kalman_angle_bias_filter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // measured_angle[31:0], gyro_rate[63:32], time_step[79:64]
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // angle_estimate[31:0], bias_estimate[63:32]
);

  localparam int unsigned PW = kabf_pkg::PROD_W;

  kabf_pkg::kabf_state_e state_q, state_d;

  logic [30:0] an_q, bn_q, mn_q;
  logic signed [31:0] angle_q, angle_d, bias_q, bias_d;
  logic signed [31:0] p00_q, p00_d, p01_q, p01_d, p10_q, p10_d, p11_q, p11_d;

  // payload registers
  logic signed [31:0] meas_q, meas_d, rate_q, rate_d;
  logic [15:0]        dt_q, dt_d;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [33:0] t_q, t_d;
  logic signed [32:0] s_q, s_d;
  logic signed [31:0] k0_q, k0_d, k1_q, k1_d;
  logic [32:0] dmag_q, dmag_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dq_q, dq_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        ovf_q, ovf_d, neg_q, neg_d, dsel_q, dsel_d;

  logic accept;
  logic signed [kabf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [kabf_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PW-17:0] sh16;
  logic signed [PW-25:0] sh24;
  logic signed [31:0] y;
  logic signed [31:0] dnum;
  logic [32:0] nmag;
  logic [33:0] rem2;
  logic [31:0] kval;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == kabf_pkg::ST_IDLE);
  assign m_axis_tvalid = (state_q == kabf_pkg::ST_OUT);
  assign m_axis_tdata  = {bias_q, angle_q};

  assign sh16 = prod_q[PW-1:16];
  assign sh24 = prod_q[PW-1:24];
  assign y    = kabf_pkg::sat32(64'(meas_q) - 64'(angle_q));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kabf_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (kabf_pkg::kabf_op_e'(s_axis_tuser) == kabf_pkg::OP_UPDATE) ?
                    kabf_pkg::ST_M0 : kabf_pkg::ST_OUT;
        end
      end
      kabf_pkg::ST_M0:   state_d = kabf_pkg::ST_M1;
      kabf_pkg::ST_M1:   state_d = kabf_pkg::ST_M2;
      kabf_pkg::ST_M2:   state_d = kabf_pkg::ST_M3;
      kabf_pkg::ST_M3:   state_d = kabf_pkg::ST_M4;
      kabf_pkg::ST_M4:   state_d = kabf_pkg::ST_SUM;
      kabf_pkg::ST_SUM:  state_d = kabf_pkg::ST_DSET;
      kabf_pkg::ST_DSET: begin
        state_d = (s_q == '0) ? kabf_pkg::ST_C0 : kabf_pkg::ST_DRUN;
      end
      kabf_pkg::ST_DRUN: begin
        if (cnt_q == '0) state_d = kabf_pkg::ST_DEND;
      end
      kabf_pkg::ST_DEND: state_d = dsel_q ? kabf_pkg::ST_C0 : kabf_pkg::ST_DSET;
      kabf_pkg::ST_C0:   state_d = kabf_pkg::ST_C1;
      kabf_pkg::ST_C1:   state_d = kabf_pkg::ST_C2;
      kabf_pkg::ST_C2:   state_d = kabf_pkg::ST_C3;
      kabf_pkg::ST_C3:   state_d = kabf_pkg::ST_C4;
      kabf_pkg::ST_C4:   state_d = kabf_pkg::ST_C5;
      kabf_pkg::ST_C5:   state_d = kabf_pkg::ST_C6;
      kabf_pkg::ST_C6:   state_d = kabf_pkg::ST_OUT;
      kabf_pkg::ST_OUT: begin
        if (m_axis_tready) state_d = kabf_pkg::ST_IDLE;
      end
      default:           state_d = kabf_pkg::ST_IDLE;
    endcase
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = $signed({16'b0, dt_q});
    unique case (state_q)
      kabf_pkg::ST_M0: mul_a = kabf_pkg::MUL_A_W'(64'(rate_q) - 64'(bias_q));
      kabf_pkg::ST_M1: mul_a = kabf_pkg::MUL_A_W'(p11_q);
      kabf_pkg::ST_M2: mul_a = $signed({5'b0, bn_q});
      kabf_pkg::ST_M3: begin
        mul_a = kabf_pkg::MUL_A_W'(64'(t_q) - 64'(p01_q) - 64'(p10_q)
                                   + 64'($signed({1'b0, an_q})));
      end
      kabf_pkg::ST_C0: begin mul_a = kabf_pkg::MUL_A_W'(y);     mul_b = k0_q; end
      kabf_pkg::ST_C1: begin mul_a = kabf_pkg::MUL_A_W'(y);     mul_b = k1_q; end
      kabf_pkg::ST_C2: begin mul_a = kabf_pkg::MUL_A_W'(p00_q); mul_b = k1_q; end
      kabf_pkg::ST_C3: begin mul_a = kabf_pkg::MUL_A_W'(p00_q); mul_b = k0_q; end
      kabf_pkg::ST_C4: begin mul_a = kabf_pkg::MUL_A_W'(p01_q); mul_b = k1_q; end
      kabf_pkg::ST_C5: begin mul_a = kabf_pkg::MUL_A_W'(p01_q); mul_b = k0_q; end
      default:         mul_a = '0;
    endcase
  end

  // Divider operands
  assign dnum = dsel_q ? p10_q : p00_q;
  assign nmag = dnum[31] ? 33'(-65'(dnum)) : {1'b0, dnum};
  assign rem2 = {rem_q, dq_q[31]};

  // Datapath updates per step
  always_comb begin
    angle_d = angle_q; bias_d = bias_q;
    p00_d = p00_q; p01_d = p01_q; p10_d = p10_q; p11_d = p11_q;
    meas_d = meas_q; rate_d = rate_q; dt_d = dt_q;
    prod_d = mul_a * mul_b;
    t_d = t_q; s_d = s_q; k0_d = k0_q; k1_d = k1_q;
    dmag_d = dmag_q; rem_d = rem_q; dq_d = dq_q; cnt_d = cnt_q;
    ovf_d = ovf_q; neg_d = neg_q; dsel_d = dsel_q;
    kval = '0;
    unique case (state_q)
      kabf_pkg::ST_IDLE: begin
        if (accept) begin
          meas_d = s_axis_tdata[31:0];
          rate_d = s_axis_tdata[63:32];
          dt_d   = s_axis_tdata[79:64];
          dsel_d = 1'b0;
          unique case (kabf_pkg::kabf_op_e'(s_axis_tuser))
            kabf_pkg::OP_FORCE: angle_d = s_axis_tdata[31:0];
            kabf_pkg::OP_CLEAR: begin
              angle_d = '0; bias_d = '0;
              p00_d = '0; p01_d = '0; p10_d = '0; p11_d = '0;
            end
            kabf_pkg::OP_UPDATE, kabf_pkg::OP_NONE: ;
            default: ;
          endcase
        end
      end
      kabf_pkg::ST_M1: angle_d = kabf_pkg::sat32(64'(angle_q) + 64'(sh16));
      kabf_pkg::ST_M2: t_d = sh16[33:0];
      kabf_pkg::ST_M3: begin
        p11_d = kabf_pkg::sat32(64'(p11_q) + 64'(sh16));
        p01_d = kabf_pkg::sat32(64'(p01_q) - 64'(t_q));
        p10_d = kabf_pkg::sat32(64'(p10_q) - 64'(t_q));
      end
      kabf_pkg::ST_M4: p00_d = kabf_pkg::sat32(64'(p00_q) + 64'(sh16));
      kabf_pkg::ST_SUM: begin
        s_d  = 33'(64'(p00_q) + 64'($signed({1'b0, mn_q})));
        k0_d = '0;
        k1_d = '0;
      end
      kabf_pkg::ST_DSET: begin
        // |num| * 2^24 >= |s| * 2^32 means the gain saturates
        dmag_d = s_q[32] ? 33'(-34'(s_q)) : 33'(s_q);
        ovf_d  = 41'(nmag) >= {dmag_d, 8'b0};
        neg_d  = dnum[31] ^ s_q[32];
        rem_d  = 33'(nmag[32:8]);
        dq_d   = {nmag[7:0], 24'b0};
        cnt_d  = 5'd31;
      end
      kabf_pkg::ST_DRUN: begin
        if (rem2 >= {1'b0, dmag_q}) begin
          rem_d = 33'(rem2 - {1'b0, dmag_q});
          dq_d  = {dq_q[30:0], 1'b1};
        end else begin
          rem_d = rem2[32:0];
          dq_d  = {dq_q[30:0], 1'b0};
        end
        cnt_d = cnt_q - 5'd1;
      end
      kabf_pkg::ST_DEND: begin
        if (ovf_q) begin
          kval = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (!neg_q) begin
          kval = dq_q[31] ? 32'h7FFF_FFFF : dq_q;
        end else begin
          kval = (dq_q > 32'h8000_0000) ? 32'h8000_0000 : 32'(-dq_q);
        end
        if (dsel_q) k1_d = kval;
        else        k0_d = kval;
        dsel_d = 1'b1;
      end
      kabf_pkg::ST_C1: angle_d = kabf_pkg::sat32(64'(angle_q) + 64'(sh24));
      kabf_pkg::ST_C2: bias_d  = kabf_pkg::sat32(64'(bias_q) + 64'(sh24));
      kabf_pkg::ST_C3: p10_d   = kabf_pkg::sat32(64'(p10_q) - 64'(sh24));
      kabf_pkg::ST_C4: p00_d   = kabf_pkg::sat32(64'(p00_q) - 64'(sh24));
      kabf_pkg::ST_C5: p11_d   = kabf_pkg::sat32(64'(p11_q) - 64'(sh24));
      kabf_pkg::ST_C6: p01_d   = kabf_pkg::sat32(64'(p01_q) - 64'(sh24));
      default: ;
    endcase
  end

  // Control, filter state and noise registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kabf_pkg::ST_IDLE;
      an_q    <= kabf_pkg::RST_ANGLE_NOISE;
      bn_q    <= kabf_pkg::RST_BIAS_NOISE;
      mn_q    <= kabf_pkg::RST_MEASURE_NOISE;
      angle_q <= '0;
      bias_q  <= '0;
      p00_q   <= '0;
      p01_q   <= '0;
      p10_q   <= '0;
      p11_q   <= '0;
      dsel_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      angle_q <= angle_d;
      bias_q  <= bias_d;
      p00_q   <= p00_d;
      p01_q   <= p01_d;
      p10_q   <= p10_d;
      p11_q   <= p11_d;
      dsel_q  <= dsel_d;
      if (cfg_we_i) begin
        unique case (kabf_pkg::kabf_reg_e'(cfg_idx_i))
          kabf_pkg::REG_ANGLE_NOISE:   an_q <= cfg_data_i;
          kabf_pkg::REG_BIAS_NOISE:    bn_q <= cfg_data_i;
          kabf_pkg::REG_MEASURE_NOISE: mn_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    meas_q <= meas_d;
    rate_q <= rate_d;
    dt_q   <= dt_d;
    prod_q <= prod_d;
    t_q    <= t_d;
    s_q    <= s_d;
    k0_q   <= k0_d;
    k1_q   <= k1_d;
    dmag_q <= dmag_d;
    rem_q  <= rem_d;
    dq_q   <= dq_d;
    cnt_q  <= cnt_d;
    ovf_q  <= ovf_d;
    neg_q  <= neg_d;
  end

endmodule

>>> verif/kalman_angle_bias_filter_unit_tb.sv
// Self-checking testbench for kalman_angle_bias_filter_unit: a fixed-point predictor
// of the filter runs beside the block and checks every result item.
// Depends on kabf_pkg and the filter RTL.
`timescale 1ns / 1ps

module kalman_angle_bias_filter_unit_tb;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam logic [30:0] NOISE_MAX = 31'h7FFF_FFFF;

  typedef struct {
    logic [31:0] angle;
    logic [31:0] bias;
  } estimate_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [30:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;  // measured_angle[31:0], gyro_rate[63:32], time_step[79:64]
  logic [1:0]  s_axis_tuser;  // opcode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;  // angle_estimate[31:0], bias_estimate[63:32]

  kalman_angle_bias_filter_unit dut (.*);

  // Predictor state and noise settings
  longint    est_angle, est_bias;
  longint    cov [4];
  longint    q_angle, q_bias, r_meas;
  estimate_t pending_estimates [$];
  int        error_count = 0;
  int        burst_left = 0;
  int        ready_mode = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("kalman_angle_bias_filter_unit test failed");
    $finish;
  end

  function automatic longint clip32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // One filter step on the predictor state; returns the estimate it reports
  function automatic estimate_t filter_step(input kabf_pkg::kabf_op_e op,
                                            input logic [31:0] meas_bits,
                                            input logic [31:0] rate_bits,
                                            input logic [15:0] dt_bits);
    longint meas, rate, dt, p00, p01, p10, p11, t, s, k0, k1, y;
    estimate_t e;
    meas = longint'(signed'(meas_bits));
    rate = longint'(signed'(rate_bits));
    dt = longint'(dt_bits);
    case (op)
      kabf_pkg::OP_UPDATE: begin
        p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
        // predict
        est_angle = clip32(est_angle + ((dt * (rate - est_bias)) >>> 16));
        t = (dt * p11) >>> 16;
        p00 = clip32(p00 + ((dt * (t - p01 - p10 + q_angle)) >>> 16));
        p01 = clip32(p01 - t);
        p10 = clip32(p10 - t);
        p11 = clip32(p11 + ((q_bias * dt) >>> 16));
        // gains, zero when the innovation variance vanishes
        s = p00 + r_meas;
        if (s == 0) begin
          k0 = 0;
          k1 = 0;
        end else begin
          k0 = clip32((p00 * 64'sd16777216) / s);
          k1 = clip32((p10 * 64'sd16777216) / s);
        end
        // correct
        y = clip32(meas - est_angle);
        est_angle = clip32(est_angle + ((k0 * y) >>> 24));
        est_bias = clip32(est_bias + ((k1 * y) >>> 24));
        cov[0] = clip32(p00 - ((k0 * p00) >>> 24));
        cov[1] = clip32(p01 - ((k0 * p01) >>> 24));
        cov[2] = clip32(p10 - ((k1 * p00) >>> 24));
        cov[3] = clip32(p11 - ((k1 * p01) >>> 24));
      end
      kabf_pkg::OP_FORCE: est_angle = meas;
      kabf_pkg::OP_CLEAR: begin
        est_angle = 0;
        est_bias = 0;
        foreach (cov[i]) cov[i] = 0;
      end
      default: ;
    endcase
    e.angle = est_angle[31:0];
    e.bias = est_bias[31:0];
    return e;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    error_count++;
  endtask

  // Send one item; called just after a rising edge, returns just after one
  task automatic send_item(input kabf_pkg::kabf_op_e op, input logic [31:0] meas,
                           input logic [31:0] rate, input logic [15:0] dt);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {dt, rate, meas};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_estimates.push_back(filter_step(op, meas, rate, dt));
    // bursts of random length, random gaps between them
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_estimates.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // One register write; returns just after the edge that follows the write
  task automatic write_noise(input kabf_pkg::kabf_reg_e idx, input logic [30:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      kabf_pkg::REG_ANGLE_NOISE: q_angle = longint'(value);
      kabf_pkg::REG_BIAS_NOISE:  q_bias = longint'(value);
      default:                   r_meas = longint'(value);
    endcase
    @(posedge clk_i);
  endtask

  // Receiver stall pattern: mode changes at random
  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) ready_mode <= $urandom_range(0, 2);
    case (ready_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      default: m_axis_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Result checker
  always @(posedge clk_i) begin
    estimate_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_estimates.size() == 0) begin
        report_mismatch("unexpected result angle", m_axis_tdata[31:0], '0);
      end else begin
        want = pending_estimates.pop_front();
        if (m_axis_tdata[31:0] !== want.angle)
          report_mismatch("angle_estimate", m_axis_tdata[31:0], want.angle);
        if (m_axis_tdata[63:32] !== want.bias)
          report_mismatch("bias_estimate", m_axis_tdata[63:32], want.bias);
      end
    end
  end

  // Field extremes, every opcode, zero innovation variance
  task automatic test_directed();
    send_item(kabf_pkg::OP_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    send_item(kabf_pkg::OP_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
    send_item(kabf_pkg::OP_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000);
    send_item(kabf_pkg::OP_NONE, 32'h1234_5678, 32'h9ABC_DEF0, 16'h5555);
    send_item(kabf_pkg::OP_FORCE, 32'h7FFF_FFFF, 32'h0, 16'h0);
    send_item(kabf_pkg::OP_UPDATE, 32'h0, 32'hFFFF_FFFF, 16'hAAAA);
    send_item(kabf_pkg::OP_FORCE, 32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(kabf_pkg::OP_UPDATE, 32'h0000_0000, 32'h0000_0000, 16'h0041);
    send_item(kabf_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(kabf_pkg::OP_UPDATE, 32'h0050_0000, 32'hFFF0_0000, 16'h0041);
    drain_results();
    // no measurement noise and no covariance: gains fall to zero
    write_noise(kabf_pkg::REG_MEASURE_NOISE, 31'd0);
    write_noise(kabf_pkg::REG_ANGLE_NOISE, 31'd0);
    send_item(kabf_pkg::OP_CLEAR, 32'h0, 32'h0, 16'h0);
    send_item(kabf_pkg::OP_UPDATE, 32'h0010_0000, 32'h0002_0000, 16'h0000);
    send_item(kabf_pkg::OP_UPDATE, 32'hFFF0_0000, 32'h0002_0000, 16'h0041);
    send_item(kabf_pkg::OP_UPDATE, 32'h0010_0000, 32'h0002_0000, 16'h0000);
    drain_results();
    // largest noise values
    write_noise(kabf_pkg::REG_ANGLE_NOISE, NOISE_MAX);
    write_noise(kabf_pkg::REG_BIAS_NOISE, NOISE_MAX);
    write_noise(kabf_pkg::REG_MEASURE_NOISE, NOISE_MAX);
    send_item(kabf_pkg::OP_CLEAR, 32'h0, 32'h0, 16'h0);
    repeat (4) send_item(kabf_pkg::OP_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    send_item(kabf_pkg::OP_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
    drain_results();
  endtask

  function automatic logic [30:0] pick_noise(input logic [30:0] dflt);
    case ($urandom_range(0, 5))
      0: return 31'd0;
      1: return NOISE_MAX;
      2: return dflt;
      3: return 31'($urandom);
      default: return 31'($urandom_range(1, 2_000_000));
    endcase
  endfunction

  // Random phases: plausible sensor tracks with some raw noise items
  task automatic test_random_tracks(input int phases, input int items_per_phase);
    int n;
    int track_angle, drift;
    logic [31:0] meas, rate;
    for (int ph = 0; ph < phases; ph++) begin
      write_noise(kabf_pkg::REG_ANGLE_NOISE, pick_noise(kabf_pkg::RST_ANGLE_NOISE));
      write_noise(kabf_pkg::REG_BIAS_NOISE, pick_noise(kabf_pkg::RST_BIAS_NOISE));
      write_noise(kabf_pkg::REG_MEASURE_NOISE, pick_noise(kabf_pkg::RST_MEASURE_NOISE));
      n = 0;
      while (n < items_per_phase) begin
        send_item(kabf_pkg::OP_CLEAR, $urandom, $urandom, 16'($urandom));
        n++;
        track_angle = $signed($urandom_range(0, 180 * 65536 * 2)) - 180 * 65536;
        drift = $signed($urandom_range(0, 65536 * 10)) - 65536 * 5;
        repeat ($urandom_range(5, 40)) begin
          case ($urandom_range(0, 19))
            0: send_item(kabf_pkg::OP_FORCE, track_angle, $urandom, 16'($urandom));
            1: send_item(kabf_pkg::OP_NONE, $urandom, $urandom, 16'($urandom));
            2, 3: send_item(kabf_pkg::OP_UPDATE, $urandom, $urandom, 16'($urandom));
            default: begin
              rate = $signed($urandom_range(0, 500 * 65536)) - 250 * 65536 + drift;
              meas = track_angle + $signed($urandom_range(0, 4 * 65536)) - 2 * 65536;
              send_item(kabf_pkg::OP_UPDATE, meas, rate, 16'($urandom_range(0, 200)));
            end
          endcase
          n++;
        end
      end
      drain_results();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = kabf_pkg::REG_ANGLE_NOISE;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = kabf_pkg::OP_UPDATE;
    est_angle = 0;
    est_bias = 0;
    foreach (cov[i]) cov[i] = 0;
    q_angle = longint'(kabf_pkg::RST_ANGLE_NOISE);
    q_bias = longint'(kabf_pkg::RST_BIAS_NOISE);
    r_meas = longint'(kabf_pkg::RST_MEASURE_NOISE);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_tracks(6, 270);

    if (error_count == 0) begin
      $display("kalman_angle_bias_filter_unit test passed");
    end else begin
      $display("kalman_angle_bias_filter_unit test failed");
    end
    $finish;
  end

endmodule
